FILE: src/gkar_pkg.sv
package gkar_pkg;

   // Request operations
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_SEED   = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_REPEAT_DELAY    = 3'd0,
      CSR_REPEAT_INTERVAL = 3'd1,
      CSR_STICKY_MASK     = 3'd2,
      CSR_DIRECTION_MASK  = 3'd3,
      CSR_AXIS_THRESHOLD  = 3'd4
   } csr_index_type;

   localparam logic [7:0]  RESET_REPEAT_DELAY    = 8'd15;
   localparam logic [7:0]  RESET_REPEAT_INTERVAL = 8'd2;
   localparam logic [15:0] RESET_STICKY_MASK     = 16'h0B6F;
   localparam logic [15:0] RESET_DIRECTION_MASK  = 16'hF000;
   localparam logic [14:0] RESET_AXIS_THRESHOLD  = 15'd2;

   // Device types at or above this read as absent
   localparam logic [7:0]  DEVICE_ABSENT = 8'hFE;
   localparam logic [7:0]  DEVICE_DIGITAL = 8'h00;

   // Stick direction bits in the merged word
   localparam logic [15:0] DIR_LEFT  = 16'h8000;
   localparam logic [15:0] DIR_DOWN  = 16'h4000;
   localparam logic [15:0] DIR_RIGHT = 16'h2000;
   localparam logic [15:0] DIR_UP    = 16'h1000;

   typedef struct packed {
      op_type             op;
      logic [7:0]         pad_kind;
      logic [15:0]        raw_buttons;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pressed;
      logic [15:0] merged_buttons;
   } rsp_payload_type;

endpackage

FILE: src/gamepad_key_auto_repeat.sv
// Channel  | Direction | Handshake          | Content
// ---------+-----------+--------------------+-----------------------------------------
// req      | in        | req_valid/req_stall | op, pad_kind, raw_buttons, axis_x/y
// rsp      | out       | rsp_valid/rsp_stall | pressed, merged_buttons
// csr      | in        | csr_valid/csr_ready | csr_index (3b), csr_data (16b)
//
// A request is captured in the input register, then the remap, threshold
// compare and repeat decision run in one pass into the result register. One
// request per cycle sustained while the response is not stalled; the repeat
// state is the only serial dependency and it settles in that single pass.
// Synchronous active-high reset clears valids, repeat state and CSRs to their
// defaults. A stalled response holds the pipe; the input register still
// fills, and req_stall rises only when both stages are full.
module gamepad_key_auto_repeat
   import gkar_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_data
);

   // Configuration
   logic [7:0]  repeat_delay_ff;
   logic [7:0]  repeat_interval_ff;
   logic [15:0] sticky_mask_ff;
   logic [15:0] direction_mask_ff;
   logic [14:0] axis_threshold_ff;

   // Pipeline
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // Repeat state
   logic [15:0] last_buttons_ff, last_buttons_in;
   logic [7:0]  repeat_timer_ff, repeat_timer_in;

   logic            out_free;
   logic            advance;
   logic [15:0]     swapped;
   logic [15:0]     merged;
   logic [15:0]     cur;
   logic [15:0]     pressed;
   logic            held;
   logic signed [16:0] ax_ext, ay_ext, pos_t, neg_t;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff    <= RESET_REPEAT_DELAY;
         repeat_interval_ff <= RESET_REPEAT_INTERVAL;
         sticky_mask_ff     <= RESET_STICKY_MASK;
         direction_mask_ff  <= RESET_DIRECTION_MASK;
         axis_threshold_ff  <= RESET_AXIS_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REPEAT_DELAY:    repeat_delay_ff    <= csr_data[7:0];
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_data[7:0];
            CSR_STICKY_MASK:     sticky_mask_ff     <= csr_data;
            CSR_DIRECTION_MASK:  direction_mask_ff  <= csr_data;
            CSR_AXIS_THRESHOLD:  axis_threshold_ff  <= csr_data[14:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // Handshake: result register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   // Byte swap, then face-button reorder (bits 4..7 reversed)
   assign swapped = {in_data_ff.raw_buttons[7:0], in_data_ff.raw_buttons[15:8]};

   // Stick compares done 17-bit signed so -threshold never overflows
   assign ax_ext = {in_data_ff.axis_x[15], in_data_ff.axis_x};
   assign ay_ext = {in_data_ff.axis_y[15], in_data_ff.axis_y};
   assign pos_t  = {2'b00, axis_threshold_ff};
   assign neg_t  = -pos_t;

   always_comb begin
      merged = {swapped[15:8], swapped[4], swapped[5], swapped[6], swapped[7],
                swapped[3:0]};
      if (in_data_ff.pad_kind != DEVICE_DIGITAL) begin
         if (ax_ext <= neg_t) begin
            merged = merged | DIR_LEFT;
         end else if (ax_ext >= pos_t) begin
            merged = merged | DIR_RIGHT;
         end
         if (ay_ext <= neg_t) begin
            merged = merged | DIR_UP;
         end else if (ay_ext >= pos_t) begin
            merged = merged | DIR_DOWN;
         end
      end
      if (in_data_ff.pad_kind >= DEVICE_ABSENT) begin
         merged = '0;  // absent pad reads as release
      end
   end

   // Held: nonzero and same as last, or overlapping last/sticky bits
   assign held = (merged != '0) &&
                 ((merged == last_buttons_ff) ||
                  ((last_buttons_ff != '0) &&
                   ((merged & (last_buttons_ff | sticky_mask_ff)) != '0)));

   always_comb begin
      last_buttons_in = last_buttons_ff;
      repeat_timer_in = repeat_timer_ff;
      pressed         = '0;
      cur             = merged;
      if (in_data_ff.op == OP_SEED) begin
         last_buttons_in = merged;
         repeat_timer_in = repeat_delay_ff;
      end else if (held) begin
         // while held, direction bits alone repeat if any are set
         if ((merged & direction_mask_ff) != '0) begin
            cur = merged & direction_mask_ff;
         end
         if (repeat_timer_ff == '0) begin
            pressed         = cur;
            repeat_timer_in = repeat_interval_ff;
         end else begin
            repeat_timer_in = repeat_timer_ff - 8'd1;
         end
      end else if (merged == '0) begin
         last_buttons_in = '0;
         repeat_timer_in = '0;
      end else begin
         // new press
         pressed         = merged;
         last_buttons_in = merged;
         repeat_timer_in = repeat_delay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_buttons_ff <= '0;
         repeat_timer_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            last_buttons_ff <= last_buttons_in;
            repeat_timer_ff <= repeat_timer_in;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.pressed        <= pressed;
         rsp_data_ff.merged_buttons <= merged;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: src/gkar_checker.sv
module gkar_checker
   import gkar_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Reported buttons always come from the merged word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.pressed & ~rsp_payload.merged_buttons) == 16'h0000)
      else $error("pressed bits outside merged word");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Input only backs up when the output is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // An unstalled request with an empty output is captured in the input register, then shows up as a valid response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
      else $error("accepted request lost");

endmodule

bind gamepad_key_auto_repeat gkar_checker u_gkar_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
